FILE: hdl/heater_mode_controller_core_defines.svh
// Assertion helpers used by the checker file.
`ifndef HEATER_MODE_CONTROLLER_CORE_DEFINES_SVH
`define HEATER_MODE_CONTROLLER_CORE_DEFINES_SVH

// Checked on every rising edge once reset is released.
`define HMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define HMC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/hmc_pkg.sv
package hmc_pkg;

  localparam int unsigned TempW   = 8;
  localparam int unsigned TensW   = 5;
  localparam int unsigned OnesW   = 4;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [TempW-1:0] OneSecReset      = 8'd10;
  localparam logic [TempW-1:0] FiveSecReset     = 8'd50;
  localparam logic [TempW-1:0] InitialTempReset = 8'd60;
  localparam logic [TempW-1:0] TempMinReset     = 8'd35;
  localparam logic [TempW-1:0] TempMaxReset     = 8'd75;
  localparam logic [TempW-1:0] TempStepReset    = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ONE_SEC       = 3'd0,
    CFG_FIVE_SEC      = 3'd1,
    CFG_FALLBACK_TEMP = 3'd2,
    CFG_TEMP_MIN      = 3'd3,
    CFG_TEMP_MAX      = 3'd4,
    CFG_TEMP_STEP     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_DISPLAY = 2'd1,
    MODE_ADJUST  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SEG_OFF    = 2'd0,
    SEG_UPDATE = 2'd1,
    SEG_BLINK  = 2'd2
  } seg_e;

  typedef struct packed {
    logic             power_up;
    logic             power_press;
    logic             plus_press;
    logic             minus_press;
    logic [TempW-1:0] average_temp;
    logic [TempW-1:0] stored_byte;
  } item_t;

  typedef struct packed {
    logic             digits_load;
    logic [TensW-1:0] digit_tens;
    logic [OnesW-1:0] digit_ones;
    logic             seg_mode_write;
    logic [1:0]       seg_mode;
    logic             heat_mode_write;
    logic             heat_enable;
    logic             save_strobe;
    logic [TempW-1:0] save_value;
    logic [TempW-1:0] set_temp_out;
    logic [1:0]       mode_out;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [TempW-1:0]   data;
  } cfg_req_t;

  typedef struct packed {
    logic [TempW-1:0] one_sec_ticks;
    logic [TempW-1:0] five_sec_ticks;
    logic [TempW-1:0] fallback_temp;
    logic [TempW-1:0] temp_min;
    logic [TempW-1:0] temp_max;
    logic [TempW-1:0] temp_step;
  } cfg_t;

  // v / 10 as (v * 205) >> 11, exact for all 8-bit v.
  function automatic logic [TensW-1:0] div10(logic [TempW-1:0] v);
    logic [18:0] p;
    p = {11'd0, v} * 19'd205;
    return p[15:11];
  endfunction

  function automatic logic [OnesW-1:0] mod10(logic [TempW-1:0] v,
                                             logic [TensW-1:0] tens);
    logic [TempW-1:0] t10;
    logic [TempW-1:0] rem;
    t10 = {3'd0, tens} * 8'd10;
    rem = v - t10;
    return rem[OnesW-1:0];
  endfunction

endpackage

FILE: hdl/hmc_chan_if.sv
interface hmc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/hmc_cfg_regs.sv
module hmc_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  hmc_chan_if.sink         cfg_i,
  output hmc_pkg::cfg_t    cfg_o
);

  hmc_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_sec_ticks  <= hmc_pkg::OneSecReset;
      cfg_q.five_sec_ticks <= hmc_pkg::FiveSecReset;
      cfg_q.fallback_temp  <= hmc_pkg::InitialTempReset;
      cfg_q.temp_min       <= hmc_pkg::TempMinReset;
      cfg_q.temp_max       <= hmc_pkg::TempMaxReset;
      cfg_q.temp_step      <= hmc_pkg::TempStepReset;
    end else if (cfg_i.valid) begin
      case (hmc_pkg::cfg_idx_e'(cfg_i.payload.index))
        hmc_pkg::CFG_ONE_SEC:       cfg_q.one_sec_ticks  <= cfg_i.payload.data;
        hmc_pkg::CFG_FIVE_SEC:      cfg_q.five_sec_ticks <= cfg_i.payload.data;
        hmc_pkg::CFG_FALLBACK_TEMP: cfg_q.fallback_temp  <= cfg_i.payload.data;
        hmc_pkg::CFG_TEMP_MIN:      cfg_q.temp_min       <= cfg_i.payload.data;
        hmc_pkg::CFG_TEMP_MAX:      cfg_q.temp_max       <= cfg_i.payload.data;
        hmc_pkg::CFG_TEMP_STEP:     cfg_q.temp_step      <= cfg_i.payload.data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/hmc_in_stage.sv
module hmc_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  hmc_chan_if.sink         item_i,
  input  logic             advance_i,
  output logic             valid_o,
  output hmc_pkg::item_t   item_o
);

  logic           valid_q;
  logic           valid_d;
  hmc_pkg::item_t item_q;
  logic           take;

  assign item_i.ready = !valid_q || advance_i;
  assign take         = item_i.valid && item_i.ready;
  assign valid_d      = take || (valid_q && !advance_i);
  assign valid_o      = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i.payload;
    end
  end

endmodule

FILE: hdl/hmc_tick.sv
module hmc_tick (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hmc_pkg::cfg_t     cfg_i,
  input  hmc_pkg::item_t    item_i,
  input  logic              advance_i,
  output hmc_pkg::result_t  result_o
);

  hmc_pkg::mode_e   mode_q, mode_d;
  logic [7:0]       set_temp_q, set_temp_d;
  logic [7:0]       blink_q, blink_d;
  logic [7:0]       idle_q, idle_d;
  logic [7:0]       disp_q, disp_d;

  logic             stored_bad;
  logic [7:0]       checked;
  logic [7:0]       blink_inc, idle_inc, disp_inc;
  logic [8:0]       plus_sum;
  logic [7:0]       minus_diff;
  logic             show;
  logic [7:0]       show_val;
  logic [4:0]       tens;
  hmc_pkg::result_t res;

  assign stored_bad = (item_i.stored_byte > cfg_i.temp_max) ||
                      (item_i.stored_byte < cfg_i.temp_min);
  assign checked    = stored_bad ? cfg_i.fallback_temp : item_i.stored_byte;
  assign blink_inc  = blink_q + 8'd1;
  assign idle_inc   = idle_q + 8'd1;
  assign disp_inc   = disp_q + 8'd1;
  assign plus_sum   = {1'b0, set_temp_q} + {1'b0, cfg_i.temp_step};
  assign minus_diff = set_temp_q - cfg_i.temp_step;
  assign tens       = hmc_pkg::div10(show_val);

  always_comb begin
    mode_d     = mode_q;
    set_temp_d = set_temp_q;
    blink_d    = blink_q;
    idle_d     = idle_q;
    disp_d     = disp_q;
    show       = 1'b0;
    show_val   = set_temp_q;
    res        = '0;

    if (item_i.power_up) begin
      set_temp_d = checked;
      if (stored_bad) begin
        res.save_strobe = 1'b1;
        res.save_value  = cfg_i.fallback_temp;
      end
      show     = 1'b1;
      show_val = checked;
    end else begin
      case (mode_q)
        hmc_pkg::MODE_DISPLAY: begin
          if (item_i.power_press) begin
            mode_d = hmc_pkg::MODE_OFF;
          end else if (item_i.plus_press || item_i.minus_press) begin
            // entering setting mode reloads the stored value, no step
            mode_d              = hmc_pkg::MODE_ADJUST;
            blink_d             = 8'd0;
            set_temp_d          = checked;
            res.heat_mode_write = 1'b1;
            show                = 1'b1;
            show_val            = checked;
          end else begin
            res.heat_mode_write = 1'b1;
            res.heat_enable     = 1'b1;
            res.seg_mode_write  = 1'b1;
            res.seg_mode        = hmc_pkg::SEG_UPDATE;
            if (disp_inc >= cfg_i.one_sec_ticks) begin
              disp_d   = 8'd0;
              show     = 1'b1;
              show_val = item_i.average_temp;
            end else begin
              disp_d = disp_inc;
            end
          end
        end
        hmc_pkg::MODE_ADJUST: begin
          if (blink_inc >= cfg_i.one_sec_ticks) begin
            res.seg_mode_write = 1'b1;
            res.seg_mode       = hmc_pkg::SEG_BLINK;
            blink_d            = 8'd0;
          end else begin
            blink_d = blink_inc;
          end
          if (item_i.plus_press) begin
            set_temp_d = (plus_sum > {1'b0, cfg_i.temp_max}) ? cfg_i.temp_max
                                                             : plus_sum[7:0];
            res.heat_mode_write = 1'b1;
            show     = 1'b1;
            show_val = set_temp_d;
            idle_d   = 8'd0;
          end else if (item_i.minus_press) begin
            set_temp_d = ((set_temp_q < cfg_i.temp_step) ||
                          (minus_diff < cfg_i.temp_min)) ? cfg_i.temp_min
                                                          : minus_diff;
            res.heat_mode_write = 1'b1;
            show     = 1'b1;
            show_val = set_temp_d;
            idle_d   = 8'd0;
          end else if (item_i.power_press) begin
            mode_d          = hmc_pkg::MODE_OFF;
            res.save_strobe = 1'b1;
            res.save_value  = set_temp_q;
          end else if (idle_inc >= cfg_i.five_sec_ticks) begin
            idle_d          = 8'd0;
            mode_d          = hmc_pkg::MODE_DISPLAY;
            res.save_strobe = 1'b1;
            res.save_value  = set_temp_q;
          end else begin
            idle_d = idle_inc;
          end
        end
        default: begin
          if (item_i.power_press) begin
            mode_d = hmc_pkg::MODE_DISPLAY;
          end else begin
            mode_d              = hmc_pkg::MODE_OFF;
            res.seg_mode_write  = 1'b1;
            res.seg_mode        = hmc_pkg::SEG_OFF;
            res.heat_mode_write = 1'b1;
          end
        end
      endcase
    end

    if (show) begin
      res.digits_load = 1'b1;
      res.digit_tens  = tens;
      res.digit_ones  = hmc_pkg::mod10(show_val, tens);
    end
    res.set_temp_out = set_temp_d;
    res.mode_out     = mode_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= hmc_pkg::MODE_OFF;
      set_temp_q <= hmc_pkg::InitialTempReset;
      blink_q    <= 8'd0;
      idle_q     <= 8'd0;
      disp_q     <= 8'd0;
    end else if (advance_i) begin
      mode_q     <= mode_d;
      set_temp_q <= set_temp_d;
      blink_q    <= blink_d;
      idle_q     <= idle_d;
      disp_q     <= disp_d;
    end
  end

endmodule

FILE: hdl/hmc_out_stage.sv
module hmc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hmc_pkg::result_t  result_i,
  output logic              free_o,
  hmc_chan_if.source        result_o
);

  logic             valid_q;
  logic             valid_d;
  hmc_pkg::result_t data_q;

  assign free_o           = !valid_q || result_o.ready;
  assign valid_d          = load_i || (valid_q && !result_o.ready);
  assign result_o.valid   = valid_q;
  assign result_o.payload = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

FILE: hdl/heater_mode_controller_core.sv
// Channel   | Dir | Payload            | Accepted when
// ----------+-----+--------------------+-----------------------
// item_i    | in  | hmc_pkg::item_t    | item_i.valid & ready
// result_o  | out | hmc_pkg::result_t  | result_o.valid & ready
// cfg_i     | in  | hmc_pkg::cfg_req_t | cfg_i.valid (always ready)
//
// One tick request per clock sustained while the result is not stalled. An
// accepted request sits in the input register; the tick decision between it
// and the result register loads the result when the result register is free.
// Reset clears mode and counters, loads the register defaults and sets
// the set temperature to the fallback_temp reset value.
// A stalled result holds; the input register then takes one more request.
module heater_mode_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  hmc_chan_if.sink    item_i,
  hmc_chan_if.source  result_o,
  hmc_chan_if.sink    cfg_i
);

  hmc_pkg::cfg_t    cfg;
  hmc_pkg::item_t   item_q;
  hmc_pkg::result_t result_d;
  logic             in_valid;
  logic             out_free;
  logic             advance;

  // The tick in the input register commits its state update and result
  // in the same cycle, only when the result register can take it.
  assign advance = in_valid && out_free;

  hmc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  hmc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (item_q)
  );

  // Mode state, counters and the per-tick decision logic.
  hmc_tick u_tick (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (item_q),
    .advance_i (advance),
    .result_o  (result_d)
  );

  hmc_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result_d),
    .free_o   (out_free),
    .result_o (result_o)
  );

endmodule

FILE: hdl/hmc_checker.sv
`include "heater_mode_controller_core_defines.svh"

module hmc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             item_valid_i,
  input logic             item_ready_i,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input hmc_pkg::result_t res_i
);

  logic item_take;
  assign item_take = item_valid_i && item_ready_i;

  `HMC_ASSERT(res_hold_a, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_i), "result changed while stalled")
  `HMC_ASSERT(res_latency_a, item_take && !res_valid_i |=> ##1 res_valid_i, "accepted request produced no result")
  `HMC_ASSERT(save_value_a, res_valid_i && res_i.save_strobe |-> res_i.save_value == res_i.set_temp_out, "saved value differs from set temperature")
  `HMC_ASSERT_ALWAYS(reset_empty_a, !rst_ni |=> !res_valid_i || !rst_ni, "result valid out of reset")

endmodule

bind heater_mode_controller_core hmc_checker u_hmc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .item_valid_i (item_i.valid),
  .item_ready_i (item_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_i        (result_o.payload)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Run limit in clock cycles, far above the slowest legal run.
  localparam int unsigned CycleLimit = 300000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  hmc_chan_if #(.payload_t(hmc_pkg::item_t))    item_if ();
  hmc_chan_if #(.payload_t(hmc_pkg::result_t))  result_if ();
  hmc_chan_if #(.payload_t(hmc_pkg::cfg_req_t)) cfg_if ();

  heater_mode_controller_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // ---------------------------------------------------------------------
  // Shadow copy of the controller: register file plus tick state.
  // ---------------------------------------------------------------------
  hmc_pkg::cfg_t  heater_regs;
  hmc_pkg::mode_e hm_mode;
  logic [7:0]     hm_set;
  logic [7:0]     hm_blink;
  logic [7:0]     hm_idle;
  logic [7:0]     hm_disp;
  logic [7:0]     hm_avg;

  hmc_pkg::item_t   tick_q[$];        // requests waiting for the driver
  hmc_pkg::result_t tick_out_q[$];    // predicted outputs, oldest first
  int unsigned pushed_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned phase_items  = 0;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;

  // Idle / stall odds in percent, changed per phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Long receiver hold-off, counted in its own process.
  int unsigned hold_left = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_ack  = 0;

  hmc_pkg::result_t mon_want;
  hmc_pkg::result_t mon_got;

  // Stored byte passes only inside [temp_min, temp_max]; else fall back.
  function automatic logic [7:0] pick_stored(logic [7:0] b, output logic bad);
    bad = (b > heater_regs.temp_max) || (b < heater_regs.temp_min);
    return bad ? heater_regs.fallback_temp : b;
  endfunction

  // One scheduler tick: updates the shadow state, returns the outputs.
  function automatic hmc_pkg::result_t predict_tick_outputs(hmc_pkg::item_t it);
    hmc_pkg::result_t r;
    logic       bad;
    logic       show;
    logic [7:0] shown;
    logic [8:0] sum;
    logic [7:0] diff;
    r     = '0;
    show  = 1'b0;
    shown = '0;
    if (it.power_up) begin
      // mode and counters untouched, only the set point is re-validated
      hm_set = pick_stored(it.stored_byte, bad);
      if (bad) begin
        r.save_strobe = 1'b1;
        r.save_value  = heater_regs.fallback_temp;
      end
      show  = 1'b1;
      shown = hm_set;
    end else begin
      case (hm_mode)
        hmc_pkg::MODE_DISPLAY: begin
          if (it.power_press) begin
            hm_mode = hmc_pkg::MODE_OFF;  // power beats plus/minus here
          end else if (it.plus_press || it.minus_press) begin
            // entering press does not step; idle count kept on purpose
            hm_mode           = hmc_pkg::MODE_ADJUST;
            hm_blink          = '0;
            hm_set            = pick_stored(it.stored_byte, bad);
            r.heat_mode_write = 1'b1;
            r.heat_enable     = 1'b0;
            show              = 1'b1;
            shown             = hm_set;
          end else begin
            r.heat_mode_write = 1'b1;
            r.heat_enable     = 1'b1;
            hm_avg            = it.average_temp;
            r.seg_mode_write  = 1'b1;
            r.seg_mode        = hmc_pkg::SEG_UPDATE;
            hm_disp           = hm_disp + 8'd1;
            if (hm_disp >= heater_regs.one_sec_ticks) begin
              show    = 1'b1;
              shown   = hm_avg;
              hm_disp = '0;
            end
          end
        end
        hmc_pkg::MODE_ADJUST: begin
          hm_blink = hm_blink + 8'd1;
          if (hm_blink >= heater_regs.one_sec_ticks) begin
            r.seg_mode_write = 1'b1;
            r.seg_mode       = hmc_pkg::SEG_BLINK;
            hm_blink         = '0;
          end
          if (it.plus_press) begin
            // 9-bit sum, no wrap before the clamp
            sum               = {1'b0, hm_set} + {1'b0, heater_regs.temp_step};
            hm_set            = (sum > {1'b0, heater_regs.temp_max}) ?
                                heater_regs.temp_max : sum[7:0];
            r.heat_mode_write = 1'b1;
            r.heat_enable     = 1'b0;
            show              = 1'b1;
            shown             = hm_set;
            hm_idle           = '0;
          end else if (it.minus_press) begin
            diff = hm_set - heater_regs.temp_step;
            if (hm_set < heater_regs.temp_step || diff < heater_regs.temp_min)
              hm_set = heater_regs.temp_min;
            else
              hm_set = diff;
            r.heat_mode_write = 1'b1;
            r.heat_enable     = 1'b0;
            show              = 1'b1;
            shown             = hm_set;
            hm_idle           = '0;
          end else if (it.power_press) begin
            hm_mode       = hmc_pkg::MODE_OFF;
            r.save_strobe = 1'b1;
            r.save_value  = hm_set;
          end else begin
            hm_idle = hm_idle + 8'd1;
            if (hm_idle >= heater_regs.five_sec_ticks) begin
              // timeout: back to display, commit the set point
              hm_idle       = '0;
              hm_mode       = hmc_pkg::MODE_DISPLAY;
              r.save_strobe = 1'b1;
              r.save_value  = hm_set;
            end
          end
        end
        default: begin
          hm_mode = hmc_pkg::MODE_OFF;
          if (it.power_press) begin
            hm_mode = hmc_pkg::MODE_DISPLAY;
          end else begin
            r.seg_mode_write  = 1'b1;
            r.seg_mode        = hmc_pkg::SEG_OFF;
            r.heat_mode_write = 1'b1;
            r.heat_enable     = 1'b0;
          end
        end
      endcase
    end
    if (show) begin
      r.digits_load = 1'b1;
      r.digit_tens  = 5'(shown / 8'd10);
      r.digit_ones  = 4'(shown % 8'd10);
    end
    r.set_temp_out = hm_set;
    r.mode_out     = hm_mode;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: holds a request until accepted, predicts at acceptance.
  // ---------------------------------------------------------------------
  logic drv_busy;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
    end else begin
      drv_busy = item_if.valid;
      if (item_if.valid && item_if.ready) begin
        tick_out_q.push_back(predict_tick_outputs(item_if.payload));
        accepted_cnt++;
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_if.payload <= tick_q.pop_front();
          item_if.valid   <= 1'b1;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: compares each accepted result with the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (tick_out_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual %h",
                   $time, result_if.payload);
        end else begin
          mon_want = tick_out_q.pop_front();
          mon_got  = result_if.payload;
          check_field("digits_load", mon_want.digits_load, mon_got.digits_load);
          check_field("digit_tens", mon_want.digit_tens, mon_got.digit_tens);
          check_field("digit_ones", mon_want.digit_ones, mon_got.digit_ones);
          check_field("seg_mode_write", mon_want.seg_mode_write, mon_got.seg_mode_write);
          check_field("seg_mode", mon_want.seg_mode, mon_got.seg_mode);
          check_field("heat_mode_write", mon_want.heat_mode_write,
                      mon_got.heat_mode_write);
          check_field("heat_enable", mon_want.heat_enable, mon_got.heat_enable);
          check_field("save_strobe", mon_want.save_strobe, mon_got.save_strobe);
          check_field("save_value", mon_want.save_value, mon_got.save_value);
          check_field("set_temp_out", mon_want.set_temp_out, mon_got.set_temp_out);
          check_field("mode_out", mon_want.mode_out, mon_got.mode_out);
        end
      end
      result_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold-off counter: a new hold_req starts a stall of the sink that lasts until hold_left counts down to zero.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_left <= 80;
      hold_ack  <= hold_req;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic int cap(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic hmc_pkg::item_t item_of(logic pu, logic pw, logic pl, logic mi,
                                             logic [7:0] avg, logic [7:0] stored);
    hmc_pkg::item_t it;
    it.power_up     = pu;
    it.power_press  = pw;
    it.plus_press   = pl;
    it.minus_press  = mi;
    it.average_temp = avg;
    it.stored_byte  = stored;
    return it;
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // Mostly a byte that validates, sometimes the exact limits, else anything.
  function automatic logic [7:0] rand_stored();
    int unsigned k;
    k = $urandom_range(9);
    if (heater_regs.temp_min <= heater_regs.temp_max) begin
      if (k == 0) return heater_regs.temp_min;
      if (k == 1) return heater_regs.temp_max;
      if (k < 7) return 8'($urandom_range(heater_regs.temp_max, heater_regs.temp_min));
    end
    return rand_byte();
  endfunction

  task automatic push(hmc_pkg::item_t it);
    tick_q.push_back(it);
    pushed_cnt++;
    phase_items++;
  endtask

  // Normal tick, now and then preceded by a power-up request.
  task automatic add_tick(logic pw, logic pl, logic mi);
    if ($urandom_range(19) == 0)
      push(item_of(1'b1, rand_bit(), rand_bit(), rand_bit(), rand_byte(), rand_stored()));
    push(item_of(1'b0, pw, pl, mi, rand_byte(), rand_stored()));
  endtask

  // Well-formed use: reach display, show a while, enter setting, step,
  // then leave by power-off or by timeout. Starts from the current mode.
  task automatic push_scene();
    hmc_pkg::mode_e m;
    int    n;
    int    k;
    while (accepted_cnt != pushed_cnt) @(posedge clk_i);
    m = hm_mode;
    if (m == hmc_pkg::MODE_ADJUST) begin
      add_tick(1'b1, 1'b0, 1'b0);
      m = hmc_pkg::MODE_OFF;
    end
    if (m == hmc_pkg::MODE_OFF) add_tick(1'b1, 1'b0, 1'b0);
    n = $urandom_range(cap(2 * heater_regs.one_sec_ticks + 1, 12));
    repeat (n) add_tick(1'b0, 1'b0, 1'b0);
    case ($urandom_range(3))
      0:       add_tick(1'b0, 1'b1, 1'b0);
      1:       add_tick(1'b0, 1'b0, 1'b1);
      2:       add_tick(1'b0, 1'b1, 1'b1);
      default: add_tick(1'b0, rand_bit(), 1'b1);
    endcase
    n = $urandom_range(6);
    repeat (n) begin
      repeat ($urandom_range(2)) add_tick(1'b0, 1'b0, 1'b0);
      k = $urandom_range(9);
      if (k < 5)
        add_tick(1'b0, 1'b1, 1'b0);
      else if (k < 9)
        add_tick(1'b0, 1'b0, 1'b1);
      else
        add_tick(1'b1, rand_bit(), 1'b1);
    end
    if ($urandom_range(1)) begin
      n = heater_regs.five_sec_ticks + 1;
      if ($urandom_range(7) != 0) n = cap(n, 24);
      repeat (n) add_tick(1'b0, 1'b0, 1'b0);
      repeat ($urandom_range(3)) add_tick(1'b0, 1'b0, 1'b0);
    end
    add_tick(1'b1, 1'b0, 1'b0);
  endtask

  // Wait until every request is in and every result is out.
  task automatic drain(int unsigned extra);
    while (accepted_cnt != pushed_cnt || tick_out_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(hmc_pkg::cfg_idx_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_if.payload <= {idx, val};
    cfg_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      hmc_pkg::CFG_ONE_SEC:       heater_regs.one_sec_ticks  = val;
      hmc_pkg::CFG_FIVE_SEC:      heater_regs.five_sec_ticks = val;
      hmc_pkg::CFG_FALLBACK_TEMP: heater_regs.fallback_temp  = val;
      hmc_pkg::CFG_TEMP_MIN:      heater_regs.temp_min       = val;
      hmc_pkg::CFG_TEMP_MAX:      heater_regs.temp_max       = val;
      hmc_pkg::CFG_TEMP_STEP:     heater_regs.temp_step      = val;
      default: ;
    endcase
  endtask

  task automatic load_regs(hmc_pkg::cfg_t c);
    write_reg(hmc_pkg::CFG_ONE_SEC, c.one_sec_ticks);
    write_reg(hmc_pkg::CFG_FIVE_SEC, c.five_sec_ticks);
    write_reg(hmc_pkg::CFG_FALLBACK_TEMP, c.fallback_temp);
    write_reg(hmc_pkg::CFG_TEMP_MIN, c.temp_min);
    write_reg(hmc_pkg::CFG_TEMP_MAX, c.temp_max);
    write_reg(hmc_pkg::CFG_TEMP_STEP, c.temp_step);
  endtask

  // 0 none, 1 sender idles, 2 receiver stalls, 3 both at lower odds.
  task automatic set_idling(int unsigned sel);
    case (sel)
      1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
      3:       begin send_idle_pct = 31; recv_stall_pct = 31; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    hmc_pkg::cfg_t c;
    logic [7:0]    lo;
    int unsigned   idle_sel;

    item_if.valid     = 1'b0;
    item_if.payload   = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.payload    = '0;
    result_if.ready   = 1'b0;

    heater_regs.one_sec_ticks  = hmc_pkg::OneSecReset;
    heater_regs.five_sec_ticks = hmc_pkg::FiveSecReset;
    heater_regs.fallback_temp  = hmc_pkg::InitialTempReset;
    heater_regs.temp_min       = hmc_pkg::TempMinReset;
    heater_regs.temp_max       = hmc_pkg::TempMaxReset;
    heater_regs.temp_step      = hmc_pkg::TempStepReset;
    hm_mode  = hmc_pkg::MODE_OFF;
    hm_set   = hmc_pkg::InitialTempReset;
    hm_blink = '0;
    hm_idle  = '0;
    hm_disp  = '0;
    hm_avg   = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: fast counters so refresh, blink and timeout show up quickly.
    load_regs(hmc_pkg::cfg_t'{8'd1, 8'd3, 8'd60, 8'd35, 8'd75, 8'd5});
    set_idling(0);
    push(item_of(0, 0, 0, 0, 8'd0, 8'd0));      // reset state seen through off tick
    push(item_of(1, 0, 0, 0, 8'd0, 8'd75));     // stored at upper limit
    push(item_of(1, 0, 0, 0, 8'd0, 8'd76));     // above limit: fallback + save
    push(item_of(1, 0, 0, 0, 8'd0, 8'd34));     // below limit
    push(item_of(1, 1, 1, 1, 8'd255, 8'd35));   // other fields ignored on power-up
    push(item_of(0, 0, 1, 1, 8'd255, 8'd255));  // off ignores plus/minus
    push(item_of(0, 1, 0, 0, 8'd0, 8'd0));      // off -> display
    push(item_of(0, 0, 0, 0, 8'd0, 8'd0));      // refresh shows 0
    push(item_of(0, 0, 0, 0, 8'd255, 8'd0));    // refresh shows 255
    push(item_of(0, 1, 1, 1, 8'd10, 8'd50));    // power wins in display
    push(item_of(0, 1, 0, 0, 8'd10, 8'd50));
    push(item_of(0, 0, 0, 1, 8'd10, 8'd200));   // enter setting, bad byte
    push(item_of(0, 1, 1, 1, 8'd10, 8'd50));    // plus wins in setting
    push(item_of(0, 0, 1, 0, 8'd10, 8'd50));
    push(item_of(0, 0, 1, 0, 8'd10, 8'd50));    // reaches max
    push(item_of(0, 0, 1, 0, 8'd10, 8'd50));    // clamps at max
    push(item_of(0, 1, 0, 1, 8'd10, 8'd50));    // minus beats power
    push(item_of(1, 0, 0, 0, 8'd10, 8'd36));    // power-up while setting
    push(item_of(0, 0, 0, 1, 8'd10, 8'd50));    // clamps at min
    push(item_of(0, 0, 0, 1, 8'd10, 8'd50));
    repeat (3) push(item_of(0, 0, 0, 0, 8'd99, 8'd50));  // timeout + save
    push(item_of(0, 0, 1, 0, 8'd10, 8'd50));    // enter setting, good byte
    push(item_of(0, 1, 0, 0, 8'd10, 8'd50));    // power-off saves

    // Random phases, each with its own register setting and idling.
    for (int ph = 1; ph <= 6; ph++) begin
      drain(4);
      case (ph)
        1: c = hmc_pkg::cfg_t'{8'd10, 8'd50, 8'd60, 8'd35, 8'd75, 8'd5};
        2: c = hmc_pkg::cfg_t'{8'd1, 8'd1, 8'd0, 8'd0, 8'd255, 8'd255};
        3: c = hmc_pkg::cfg_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd1};
        4: c = hmc_pkg::cfg_t'{8'd3, 8'd7, 8'd200, 8'd100, 8'd20, 8'd7};  // limits crossed
        default: begin
          lo = 8'($urandom_range(200));
          c  = hmc_pkg::cfg_t'{8'($urandom_range(8, 1)), 8'($urandom_range(20, 2)),
                               rand_byte(), lo, 8'($urandom_range(255, lo)),
                               8'($urandom_range(30, 1))};
        end
      endcase
      load_regs(c);
      case (ph)
        1:       idle_sel = 1;
        2:       idle_sel = 2;
        3:       idle_sel = 3;
        4:       idle_sel = 0;
        5:       idle_sel = 3;
        default: idle_sel = 0;
      endcase
      set_idling(idle_sel);
      if (ph == 6) begin
        // Sink holds off while the source keeps offering requests.
        @(posedge clk_i);
        hold_req <= hold_req + 1;
      end
      phase_items = 0;
      while (phase_items < 55) begin
        if ($urandom_range(9) < 7) begin
          push_scene();
        end else begin
          repeat ($urandom_range(4, 1))
            push(item_of($urandom_range(7) == 0, rand_bit(), rand_bit(),
                         rand_bit(), rand_byte(), rand_byte()));
        end
      end
    end

    drain(10);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/hmc_pkg.sv
hdl/hmc_chan_if.sv
hdl/hmc_cfg_regs.sv
hdl/hmc_in_stage.sv
hdl/hmc_tick.sv
hdl/hmc_out_stage.sv
hdl/heater_mode_controller_core.sv
hdl/hmc_checker.sv
verif/tb_top.sv
